// File: rtl/core/iem_pkg.sv
package iem_pkg;

    // fraction bits of the base-2 logarithm
    localparam int LOG_FRAC = 24;
    // log2(10) in q.24, rounded to nearest
    localparam logic [31:0] LOG2_TEN_Q24 = 32'd55732705;
    // psnr in 1/256 db: 10 * 256 per decade
    localparam logic [15:0] SNR_MAX = 16'hFFFF;
    // 2560 / LOG2_TEN_Q24 scaled by 2^40, truncated
    localparam int SNR_SHIFT = 40;
    localparam logic [25:0] SNR_RECIP = 26'((64'd2560 << SNR_SHIFT) / 64'(LOG2_TEN_Q24));

    typedef struct packed {
        logic [15:0] pixel_ref;
        logic [15:0] pixel_test;
        logic        last_pixel;
    } in_word_t;

    typedef struct packed {
        logic [39:0] mean_sq_error;
        logic [23:0] mean_abs_error;
        logic [15:0] peak_snr;
        logic        perfect_match;
        logic [24:0] pixel_total;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_SQ,
        ST_DIV_ABS,
        ST_NORM,
        ST_LOG,
        ST_SQR_MAX,
        ST_MUL_N,
        ST_SNR_MUL,
        ST_SNR_FIX,
        ST_DONE
    } back_state_t;

endpackage

// File: rtl/core/iem_queue.sv
module iem_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("queue written while full");
`endif

endmodule

// File: rtl/core/iem_front.sv
module iem_front #(
    parameter int PIXEL_BITS = 16,
    parameter int COUNT_BITS = 24,
    localparam int SQ_W  = 2 * PIXEL_BITS + COUNT_BITS,
    localparam int ABS_W = PIXEL_BITS + COUNT_BITS,
    localparam int CNT_W = COUNT_BITS + 1,
    localparam int ENT_W = SQ_W + ABS_W + CNT_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  iem_pkg::in_word_t in_data,
    input  logic              q_full,
    output logic              q_push,
    output logic [ENT_W-1:0]  q_data
);

    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [ABS_W-1:0]        abs_reg, abs_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [PIXEL_BITS-1:0]   a, b, d;
    logic [2*PIXEL_BITS-1:0] d_sq;
    logic                    accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && in_data.last_pixel;
    assign q_data   = {sq_next, abs_next, cnt_next};

    // difference and running sums, pairs beyond the count limit are dropped
    always_comb
    begin
        a = in_data.pixel_ref[PIXEL_BITS-1:0];
        b = in_data.pixel_test[PIXEL_BITS-1:0];
        d = (a >= b) ? (a - b) : (b - a);
        d_sq = (2*PIXEL_BITS)'(d) * (2*PIXEL_BITS)'(d);
        sq_next  = sq_reg;
        abs_next = abs_reg;
        cnt_next = cnt_reg;
        if (!cnt_reg[CNT_W-1])
        begin
            sq_next  = sq_reg + SQ_W'(d_sq);
            abs_next = abs_reg + ABS_W'(d);
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_reg  <= '0;
            abs_reg <= '0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (in_data.last_pixel)
            begin
                sq_reg  <= '0;
                abs_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                sq_reg  <= sq_next;
                abs_reg <= abs_next;
                cnt_reg <= cnt_next;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[CNT_W-1] |-> cnt_reg[CNT_W-2:0] == '0)
        else $error("pair count beyond limit");
`endif

endmodule

// File: rtl/core/iem_back.sv
module iem_back #(
    parameter int PIXEL_BITS = 16,
    parameter int COUNT_BITS = 24,
    localparam int SQ_W  = 2 * PIXEL_BITS + COUNT_BITS,
    localparam int ABS_W = PIXEL_BITS + COUNT_BITS,
    localparam int CNT_W = COUNT_BITS + 1,
    localparam int ENT_W = SQ_W + ABS_W + CNT_W,
    localparam int NUM_W = (SQ_W + 8 > 42) ? SQ_W + 8 : 42,
    localparam int DEN_W = 32,
    localparam int DC_W  = $clog2(NUM_W + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  logic [ENT_W-1:0]   q_data,
    output logic               q_pop,
    input  logic [15:0]        max_value,
    output logic               out_valid,
    input  logic               out_ready,
    output iem_pkg::out_word_t out_data
);

    iem_pkg::back_state_t state_reg, state_next;

    logic [SQ_W-1:0]  sq_reg;
    logic [ABS_W-1:0] abs_reg;
    logic [CNT_W-1:0] n_reg;

    // shared restoring divider
    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DC_W-1:0]  dcnt_reg;
    logic [DEN_W:0]   rem_sh;
    logic             rem_ge;

    // logarithm unit
    logic [63:0] lx_reg;
    logic [5:0]  le_reg;
    logic [31:0] lm_reg;
    logic [23:0] lf_reg;
    logic [4:0]  lcnt_reg;
    logic        lphase_reg;
    logic [29:0] lb_reg;
    logic [29:0] la;
    logic [63:0] lsq;
    logic [31:0] lt;

    // psnr scaling by reciprocal multiply and one correction step
    logic [29:0] snr_d_reg;
    logic [41:0] snr_x_reg;
    logic [16:0] snr_q_reg;
    logic [56:0] snr_prod;
    logic [42:0] snr_qk;
    logic        snr_up;
    logic [16:0] snr_q1;

    logic [31:0] max_sq_reg;
    logic [39:0] mse_reg;
    logic [23:0] mae_reg;
    logic [15:0] snr_reg;
    logic        pm_reg;
    logic        out_valid_reg;
    iem_pkg::out_word_t out_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign q_pop     = (state_reg == iem_pkg::ST_IDLE) && q_not_empty;

    // divider step, squaring step and psnr scaling
    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[NUM_W-1]};
        rem_ge   = (rem_sh >= {1'b0, den_reg});
        lsq      = 64'(lm_reg) * 64'(lm_reg);
        lt       = lsq[61:30];
        la       = {le_reg, lf_reg};
        snr_prod = 57'(snr_d_reg) * 57'(iem_pkg::SNR_RECIP);
        snr_qk   = 43'(snr_q_reg) * 43'(iem_pkg::LOG2_TEN_Q24);
        snr_up   = ({1'b0, snr_x_reg} >= snr_qk + 43'(iem_pkg::LOG2_TEN_Q24));
        snr_q1   = snr_q_reg + {16'd0, snr_up};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iem_pkg::ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    state_next = (q_data[ENT_W-1 -: SQ_W] == '0) ? iem_pkg::ST_DONE
                                                                  : iem_pkg::ST_DIV_SQ;
                end
            end
            iem_pkg::ST_DIV_SQ:
            begin
                if (dcnt_reg == DC_W'(NUM_W - 1))
                begin
                    state_next = iem_pkg::ST_DIV_ABS;
                end
            end
            iem_pkg::ST_DIV_ABS:
            begin
                if (dcnt_reg == DC_W'(NUM_W - 1))
                begin
                    state_next = (max_value == '0) ? iem_pkg::ST_DONE : iem_pkg::ST_NORM;
                end
            end
            iem_pkg::ST_NORM:
            begin
                if (lx_reg[63] || le_reg == '0)
                begin
                    state_next = iem_pkg::ST_LOG;
                end
            end
            iem_pkg::ST_LOG:
            begin
                if (lcnt_reg == 5'(iem_pkg::LOG_FRAC))
                begin
                    if (!lphase_reg)
                    begin
                        state_next = iem_pkg::ST_SQR_MAX;
                    end
                    else
                    begin
                        state_next = (la <= lb_reg) ? iem_pkg::ST_DONE
                                                    : iem_pkg::ST_SNR_MUL;
                    end
                end
            end
            iem_pkg::ST_SQR_MAX:
            begin
                state_next = iem_pkg::ST_MUL_N;
            end
            iem_pkg::ST_MUL_N:
            begin
                state_next = iem_pkg::ST_NORM;
            end
            iem_pkg::ST_SNR_MUL:
            begin
                state_next = iem_pkg::ST_SNR_FIX;
            end
            iem_pkg::ST_SNR_FIX:
            begin
                state_next = iem_pkg::ST_DONE;
            end
            iem_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = iem_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iem_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= iem_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == iem_pkg::ST_DONE && (!out_valid_reg || out_ready))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            iem_pkg::ST_IDLE:
            begin
                sq_reg  <= q_data[ENT_W-1 -: SQ_W];
                abs_reg <= q_data[CNT_W +: ABS_W];
                n_reg   <= q_data[CNT_W-1:0];
                mse_reg <= '0;
                mae_reg <= '0;
                snr_reg <= iem_pkg::SNR_MAX;
                pm_reg  <= 1'b1;
                // first division: sq_sum * 256 / n
                num_reg  <= NUM_W'({q_data[ENT_W-1 -: SQ_W], 8'd0});
                den_reg  <= DEN_W'(q_data[CNT_W-1:0]);
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            iem_pkg::ST_DIV_SQ, iem_pkg::ST_DIV_ABS:
            begin
                num_reg  <= {num_reg[NUM_W-2:0], 1'b0};
                quot_reg <= {quot_reg[NUM_W-2:0], rem_ge};
                rem_reg  <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
                dcnt_reg <= dcnt_reg + 1'b1;
                pm_reg   <= 1'b0;
                if (dcnt_reg == DC_W'(NUM_W - 1))
                begin
                    rem_reg  <= '0;
                    dcnt_reg <= '0;
                    if (state_reg == iem_pkg::ST_DIV_SQ)
                    begin
                        mse_reg <= 40'({quot_reg[NUM_W-2:0], rem_ge});
                        num_reg <= NUM_W'({abs_reg, 8'd0});
                    end
                    else
                    begin
                        mae_reg    <= 24'({quot_reg[NUM_W-2:0], rem_ge});
                        snr_reg    <= '0;
                        lx_reg     <= 64'(sq_reg);
                        le_reg     <= 6'd63;
                        lphase_reg <= 1'b0;
                    end
                end
            end
            iem_pkg::ST_NORM:
            begin
                // leading one found one bit a cycle
                lm_reg   <= {1'b0, lx_reg[63:33]};
                lf_reg   <= '0;
                lcnt_reg <= '0;
                if (!(lx_reg[63] || le_reg == '0))
                begin
                    lx_reg <= {lx_reg[62:0], 1'b0};
                    le_reg <= le_reg - 1'b1;
                end
            end
            iem_pkg::ST_LOG:
            begin
                if (lcnt_reg == 5'(iem_pkg::LOG_FRAC))
                begin
                    lb_reg <= la;
                    // snr numerator: difference times 2560
                    snr_d_reg <= la - lb_reg;
                    snr_x_reg <= {12'd0, la - lb_reg} * 42'd2560;
                end
                else
                begin
                    lcnt_reg <= lcnt_reg + 1'b1;
                    lf_reg   <= {lf_reg[22:0], lt[31]};
                    lm_reg   <= lt[31] ? {1'b0, lt[31:1]} : lt;
                end
            end
            iem_pkg::ST_SQR_MAX:
            begin
                max_sq_reg <= 32'(max_value) * 32'(max_value);
            end
            iem_pkg::ST_MUL_N:
            begin
                lx_reg     <= 64'(max_sq_reg) * 64'(n_reg);
                le_reg     <= 6'd63;
                lphase_reg <= 1'b1;
            end
            iem_pkg::ST_SNR_MUL:
            begin
                // estimate, at most one below the true quotient
                snr_q_reg <= snr_prod[56:40];
            end
            iem_pkg::ST_SNR_FIX:
            begin
                if (snr_q1 > 17'(iem_pkg::SNR_MAX))
                begin
                    snr_reg <= iem_pkg::SNR_MAX;
                end
                else
                begin
                    snr_reg <= snr_q1[15:0];
                end
            end
            iem_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_reg.mean_sq_error  <= mse_reg;
                    out_reg.mean_abs_error <= mae_reg;
                    out_reg.peak_snr       <= snr_reg;
                    out_reg.perfect_match  <= pm_reg;
                    out_reg.pixel_total    <= 25'(n_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg != iem_pkg::ST_IDLE)
        else $error("pop without leaving idle");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_reg))
        else $error("result dropped while stalled");
`endif

endmodule

// File: rtl/core/image_error_metrics_top.sv
// channel   direction  payload
// in        input      pixel_ref, pixel_test, last_pixel
// out       output     mean_sq_error, mean_abs_error, peak_snr, perfect_match, pixel_total
// cfg       input      max_value
//
// the front accumulates one pair a cycle unless q_full (one multiplier, one wide add)
// on a last pair the sums go into a two-word queue and the next image starts at once
// the back runs two bit-serial divisions, then the logarithms of the squared-error sum
// and of max_value squared times n, then a reciprocal multiply and a correction step
// a perfect match skips all of that
// in stalls only when the queue holds two images waiting; reset clears all sums
module image_error_metrics_top #(
    parameter int PIXEL_BITS = 16,
    parameter int COUNT_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  iem_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output iem_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);

    localparam int ENT_W = 3 * PIXEL_BITS + 3 * COUNT_BITS + 1;

    logic [15:0]      max_value_reg;
    logic             q_full, q_push, q_pop, q_not_empty;
    logic [ENT_W-1:0] q_wdata, q_rdata;

    // peak value register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg <= 16'd255;
        end
        else if (cfg_valid)
        begin
            max_value_reg <= cfg_data;
        end
    end

    iem_front #(.PIXEL_BITS(PIXEL_BITS), .COUNT_BITS(COUNT_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    iem_queue #(.WIDTH(ENT_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_rdata)
    );

    iem_back #(.PIXEL_BITS(PIXEL_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .max_value   (max_value_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int CLK_HALF   = 4;
    localparam int SETTLE     = 600;
    localparam int CYCLE_CAP  = 2000000;
    localparam int LONG_HOLD  = 3000;
    localparam int RANDOM_PAIRS = 1000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    iem_pkg::in_word_t   in_data;
    logic       out_valid;
    logic       out_ready;
    iem_pkg::out_word_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [15:0] cfg_data;

    // pairs waiting to go out, and metrics expected back
    iem_pkg::in_word_t   pair_queue[$];
    iem_pkg::out_word_t  metrics_due[$];

    // predictor state
    logic [63:0] peak_level;
    logic [63:0] sq_total;
    logic [63:0] abs_total;
    logic [63:0] pairs_seen;

    int unsigned cycles;
    int unsigned errors;
    int unsigned idle_pct;
    int unsigned long_hold_at;
    int unsigned hold_left;
    int unsigned images_checked;
    int unsigned pairs_sent;
    int unsigned words_built;

    image_error_metrics_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // base-2 logarithm in q.24 by repeated squaring of the mantissa
    function automatic logic [63:0] log2_q24(logic [63:0] x);
        int          e;
        int          i;
        logic [63:0] m;
        logic [63:0] f;
        e = 63;
        while (e > 0 && !x[e])
            e--;
        if (e >= 30)
            m = x >> (e - 30);
        else
            m = x << (30 - e);
        f = 64'd0;
        for (i = 0; i < iem_pkg::LOG_FRAC; i++)
        begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= 64'h8000_0000)
            begin
                m = m >> 1;
                f = f | 64'd1;
            end
        end
        return (64'(e) << iem_pkg::LOG_FRAC) | f;
    endfunction

    // accumulate one pair; on the last pair queue the image metrics
    function automatic void predict_metrics(iem_pkg::in_word_t w);
        logic [63:0] d;
        logic [63:0] la;
        logic [63:0] lb;
        logic [63:0] snr;
        iem_pkg::out_word_t r;
        d = (w.pixel_ref >= w.pixel_test) ? 64'(w.pixel_ref - w.pixel_test)
                                          : 64'(w.pixel_test - w.pixel_ref);
        if (pairs_seen < 64'd16777216)
        begin
            sq_total   = sq_total + d * d;
            abs_total  = abs_total + d;
            pairs_seen = pairs_seen + 1;
        end
        if (w.last_pixel)
        begin
            r = '0;
            r.pixel_total = 25'(pairs_seen);
            if (sq_total == 0)
            begin
                r.perfect_match = 1'b1;
                r.peak_snr      = iem_pkg::SNR_MAX;
            end
            else
            begin
                r.mean_sq_error  = 40'(((sq_total / pairs_seen) << 8)
                                       + ((sq_total % pairs_seen) << 8) / pairs_seen);
                r.mean_abs_error = 24'((abs_total << 8) / pairs_seen);
                snr = 64'd0;
                if (peak_level != 0)
                begin
                    la = log2_q24(peak_level * peak_level * pairs_seen);
                    lb = log2_q24(sq_total);
                    if (la > lb)
                    begin
                        snr = ((la - lb) * 64'd2560) / 64'(iem_pkg::LOG2_TEN_Q24);
                        if (snr > 64'(iem_pkg::SNR_MAX))
                            snr = 64'(iem_pkg::SNR_MAX);
                    end
                end
                r.peak_snr = 16'(snr);
            end
            metrics_due.push_back(r);
            sq_total   = 0;
            abs_total  = 0;
            pairs_seen = 0;
        end
    endfunction

    // cycle count and timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, metrics_due.size());
            $display("image_error_metrics_top test failed");
            $finish;
        end
    end

    // pair driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                predict_metrics(in_data);
                pairs_sent++;
            end
            if (pair_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                in_data  <= pair_queue.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // metrics monitor, with random stalls and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (metrics_due.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected word %h", $realtime, out_data);
                end
                else
                begin
                    if (out_data !== metrics_due[0])
                    begin
                        errors++;
                        $display("%0t mismatch expected mse %h mae %h snr %h pm %b n %h",
                                 $realtime, metrics_due[0].mean_sq_error,
                                 metrics_due[0].mean_abs_error, metrics_due[0].peak_snr,
                                 metrics_due[0].perfect_match, metrics_due[0].pixel_total);
                        $display("%0t          actual   mse %h mae %h snr %h pm %b n %h",
                                 $realtime, out_data.mean_sq_error,
                                 out_data.mean_abs_error, out_data.peak_snr,
                                 out_data.perfect_match, out_data.pixel_total);
                    end
                    void'(metrics_due.pop_front());
                    images_checked++;
                end
            end
            if (cycles == long_hold_at)
            begin
                hold_left <= LONG_HOLD;
                out_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // one image of n pairs; style picks the pixel pattern
    task automatic build_image(int n, int style);
        iem_pkg::in_word_t w;
        int       i;
        logic [15:0] d;
        for (i = 0; i < n; i++)
        begin
            w.pixel_ref  = 16'($urandom);
            case (style)
                0: w.pixel_test = w.pixel_ref;
                1:
                begin
                    d = 16'($urandom_range(0, 3));
                    w.pixel_test = $urandom_range(0, 1) ? w.pixel_ref + d : w.pixel_ref - d;
                end
                2:
                begin
                    w.pixel_ref  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    w.pixel_test = ~w.pixel_ref;
                end
                default: w.pixel_test = 16'($urandom);
            endcase
            w.last_pixel = (i == n - 1);
            pair_queue.push_back(w);
            words_built++;
        end
    endtask

    task automatic write_peak(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        peak_level = 64'(v);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pair_queue.size() > 0 || in_valid || metrics_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_images(int pairs);
        int goal;
        goal = words_built + pairs;
        while (words_built < goal)
        begin
            if ($urandom_range(0, 19) == 0)
                build_image($urandom_range(30, 64), $urandom_range(0, 3));
            else
                build_image($urandom_range(1, 8), $urandom_range(0, 5));
        end
    endtask

    logic [15:0] peak_steps[7];
    int          p;

    initial
    begin
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        cycles       = 0;
        errors       = 0;
        idle_pct     = 19;
        long_hold_at = 0;
        images_checked = 0;
        pairs_sent   = 0;
        words_built  = 0;
        peak_level   = 64'd255;
        sq_total     = 0;
        abs_total    = 0;
        pairs_seen   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, perfect match, psnr below zero, mixed image
        begin
            iem_pkg::in_word_t w;
            w = '{16'h0000, 16'hFFFF, 1'b1};  pair_queue.push_back(w);
            w = '{16'hFFFF, 16'h0000, 1'b1};  pair_queue.push_back(w);
            w = '{16'h1234, 16'h1234, 1'b1};  pair_queue.push_back(w);
            w = '{16'hAAAA, 16'h5555, 1'b0};  pair_queue.push_back(w);
            w = '{16'h5555, 16'hAAAA, 1'b1};  pair_queue.push_back(w);
            w = '{16'h0080, 16'h0081, 1'b1};  pair_queue.push_back(w);
            w = '{16'h0000, 16'h0000, 1'b0};  pair_queue.push_back(w);
            w = '{16'hFFFF, 16'hFFFF, 1'b0};  pair_queue.push_back(w);
            w = '{16'h00FF, 16'h00FF, 1'b1};  pair_queue.push_back(w);
            w = '{16'h0010, 16'h0013, 1'b0};  pair_queue.push_back(w);
            w = '{16'h0020, 16'h0020, 1'b0};  pair_queue.push_back(w);
            w = '{16'h7FFF, 16'h8000, 1'b1};  pair_queue.push_back(w);
        end
        drain();

        // several peak settings, extremes among them
        peak_steps = '{16'd0, 16'd1, 16'hFFFF, 16'd255, 16'd0, 16'd0, 16'd1023};
        peak_steps[4] = 16'($urandom);
        peak_steps[5] = 16'($urandom);
        for (p = 0; p < 7; p++)
        begin
            write_peak(peak_steps[p]);
            // extremes again under this setting
            build_image(1, 2);
            build_image(2, 0);
            if (p == 2)
                long_hold_at = cycles + 20;
            idle_pct = (p == 3) ? 0 : 19;
            random_images(RANDOM_PAIRS / 7);
            drain();
        end

        $display("covered %0d pixel pairs in %0d images over %0d peak settings",
                 pairs_sent, images_checked, 8);
        $display("including single-pair, perfect-match, full-swing and stalled output cases");
        if (errors == 0)
            $display("image_error_metrics_top test passed");
        else
            $display("image_error_metrics_top test failed");
        $finish;
    end

endmodule
